@@ src/utf8_cyrillic_lcd_recoder_top_macros.svh @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder assertion macros
// Shared property shorthands for the checker, clocked on clk, reset arst_n.
// ---------------------------------------------------------------------------
`ifndef UTF8_CYRILLIC_LCD_RECODER_TOP_MACROS_SVH
`define UTF8_CYRILLIC_LCD_RECODER_TOP_MACROS_SVH

// same-cycle implication
`define UCL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("recoder check failed");

// next-cycle implication
`define UCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("recoder check failed");

`endif

@@ src/ucl_pkg.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder package
// Shared types, byte constants and the Cyrillic recode table.
// ---------------------------------------------------------------------------
package ucl_pkg;

	localparam logic [7:0] LEAD_D0     = 8'hD0;
	localparam logic [7:0] LEAD_D1     = 8'hD1;
	localparam logic [7:0] LEAD_END    = 8'hD2;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hC0;
	localparam logic [5:0] LOW_MASK    = 6'h3F;
	localparam logic [5:0] IDX_YO_UP   = 6'h01;
	localparam logic [5:0] IDX_YO_LO   = 6'h11;
	localparam logic [7:0] CODE_YO_UP  = 8'hA2;
	localparam logic [7:0] CODE_YO_LO  = 8'hB5;

	localparam logic [5:0] WIDTH_RESET = 6'd20;

	localparam logic [1:0] PEND_NONE   = 2'd0;
	localparam logic [1:0] PEND_D0     = 2'd1;
	localparam logic [1:0] PEND_D1     = 2'd2;

	localparam int         OUTQ_DEPTH  = 3;

	localparam logic [7:0] RECODE_ROM [64] = '{
		8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
		8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
		8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
		8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
		8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
		8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
		8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
		8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE
	};

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       done;
	} ucl_res_t;

	typedef struct packed {
		logic [1:0] count;
		ucl_res_t   res0;
		ucl_res_t   res1;
	} ucl_emit_t;

endpackage

@@ src/ucl_decode.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder decode stage
// Holds the pending lead and the line position, and turns one byte into
// zero, one or two display codes.
// ---------------------------------------------------------------------------
module ucl_decode
	import ucl_pkg::*;
#(
	parameter int MAX_COLUMNS = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [5:0] line_width,
	input  logic       fire,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output ucl_emit_t  emit
);

	localparam int PW = $clog2(MAX_COLUMNS + 1);
	localparam int WW = (PW > 6) ? PW : 6;

	logic [1:0]    pend_q, pend_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [WW-1:0] w_raw, w_lim;
	logic [PW-1:0] w_eff;
	logic [PW:0]   pos_inc;
	logic          is_lead, is_cont, is_end;
	logic [7:0]    lead, rom_code;
	logic [5:0]    low;

	always_comb begin
		w_raw = WW'(line_width);
		w_lim = w_raw;
		if (w_raw == '0) begin
			w_lim = WW'(1);
		end else if (w_raw > WW'(MAX_COLUMNS)) begin
			w_lim = WW'(MAX_COLUMNS);
		end
		w_eff = w_lim[PW-1:0];
	end

	assign pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
	assign is_lead  = (text_byte == LEAD_D0) || (text_byte == LEAD_D1);
	assign is_cont  = (text_byte >= CONT_LO) && (text_byte < CONT_HI);
	assign is_end   = line_end || (pos_inc >= {1'b0, w_eff});
	assign lead     = (pend_q == PEND_D1) ? LEAD_D1 : LEAD_D0;
	assign low      = text_byte[5:0] & LOW_MASK;

	always_comb begin
		rom_code = RECODE_ROM[low];
		if (low == IDX_YO_UP && pend_q == PEND_D0) begin
			rom_code = CODE_YO_UP;
		end
		if (low == IDX_YO_LO && pend_q == PEND_D1) begin
			rom_code = CODE_YO_LO;
		end
	end

	always_comb begin
		pend_d     = pend_q;
		pos_d      = pos_q;
		emit.count = 2'd0;
		emit.res0  = '{code: text_byte, last: 1'b1, done: is_end};
		emit.res1  = '{code: text_byte, last: 1'b1, done: is_end};
		if (pos_q >= w_eff) begin
			if (line_end) begin
				pos_d  = '0;
				pend_d = PEND_NONE;
			end
		end else begin
			if (!is_end) begin
				pos_d = pos_inc[PW-1:0];
			end else if (line_end) begin
				pos_d = '0;
			end else begin
				pos_d = w_eff;
			end
			pend_d = PEND_NONE;
			if (pend_q != PEND_NONE) begin
				if (is_cont) begin
					emit.count = 2'd1;
					emit.res0  = '{code: rom_code, last: 1'b1, done: is_end};
				end else if (is_lead && !is_end) begin
					pend_d     = text_byte[0] ? PEND_D1 : PEND_D0;
					emit.count = 2'd1;
					emit.res0  = '{code: lead, last: 1'b1, done: 1'b0};
				end else begin
					emit.count = 2'd2;
					emit.res0  = '{code: lead, last: 1'b0, done: 1'b0};
				end
			end else if (is_lead && !is_end) begin
				pend_d = text_byte[0] ? PEND_D1 : PEND_D0;
			end else begin
				emit.count = 2'd1;
			end
		end
		if (!fire) begin
			emit.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			pos_q  <= '0;
		end else if (fire) begin
			pend_q <= pend_d;
			pos_q  <= pos_d;
		end
	end

endmodule

@@ src/ucl_outq.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder result queue
// Three-entry shift queue that takes up to two results per cycle and
// presents the oldest one on the output stream.
// ---------------------------------------------------------------------------
module ucl_outq
	import ucl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ucl_emit_t emit,
	input  logic      pop,
	output logic      room,
	output logic      head_valid,
	output ucl_res_t  head
);

	ucl_res_t   ent_q [OUTQ_DEPTH];
	ucl_res_t   ent_d [OUTQ_DEPTH];
	logic [1:0] count_q, count_d, cap;

	assign cap        = count_q - {1'b0, pop};
	assign room       = (cap <= 2'd1);
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[0];
	assign count_d    = cap + emit.count;

	always_comb begin
		for (int i = 0; i < OUTQ_DEPTH; i++) begin
			if (pop && i < OUTQ_DEPTH - 1) begin
				ent_d[i] = ent_q[i + 1];
			end else begin
				ent_d[i] = ent_q[i];
			end
			if (emit.count != 2'd0 && 2'(i) == cap) begin
				ent_d[i] = emit.res0;
			end
			if (emit.count == 2'd2 && 2'(i) == cap + 2'd1) begin
				ent_d[i] = emit.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OUTQ_DEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

endmodule

@@ src/utf8_cyrillic_lcd_recoder_top.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder
// Recodes the UTF-8 bytes of one display line into HD44780 Cyrillic codes.
// ---------------------------------------------------------------------------
// Slave stream: one text byte per transaction, tlast marks the line end.
// Master stream: one character code per transaction; tuser is set on the
// last code caused by an input byte, tlast on the final code of the line
// (after truncation to the configured width).
// cfg_wr_en / cfg_wr_data write the line width (1..MAX_COLUMNS, 0 acts as 1);
// write it only while the block is idle.
// A code passes through the input register and the result queue before it
// is valid on the master side.
// Throughput: one byte per cycle; a byte that yields two codes needs a
// second output transfer, so a run of them backs up the result queue and the
// input register holds once two codes wait after the current pop.
// Reset clears the pending lead, the line position and the queue, and sets
// the width to 20. When the receiver stalls, the result queue stops taking
// bytes once two codes wait, and tready falls when the input register is
// also full; nothing is dropped.
// ---------------------------------------------------------------------------
module utf8_cyrillic_lcd_recoder_top
	import ucl_pkg::*;
#(
	parameter int MAX_COLUMNS = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // line_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_code
	output logic       m_tlast,   // line_done
	output logic       m_tuser    // [0] last_of_run
);

	logic [5:0] line_width_q;
	logic       valid_s1, line_end_s1;
	logic [7:0] byte_s1;
	logic       advance, room, pop;
	ucl_emit_t  emit;
	ucl_res_t   head;

	assign pop      = m_tvalid && m_tready;
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1     <= s_tdata;
			line_end_s1 <= s_tlast;
		end
	end

	ucl_decode #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_width(line_width_q),
		.fire      (advance),
		.text_byte (byte_s1),
		.line_end  (line_end_s1),
		.emit      (emit)
	);

	ucl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.pop       (pop),
		.room      (room),
		.head_valid(m_tvalid),
		.head      (head)
	);

	assign m_tdata = head.code;
	assign m_tlast = head.done;
	assign m_tuser = head.last;

endmodule

@@ src/ucl_checker.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder port checker
// Watches the top level's ports and flags broken result sequences.
// ---------------------------------------------------------------------------
`include "utf8_cyrillic_lcd_recoder_top_macros.svh"

module ucl_checker
	import ucl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	`UCL_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`UCL_ASSERT_IMPL(a_done_on_last, m_tvalid && m_tlast, m_tuser)
	`UCL_ASSERT_IMPL(a_first_is_lead, m_tvalid && !m_tuser, m_tdata == LEAD_D0 || m_tdata == LEAD_D1)
	`UCL_ASSERT_NEXT(a_second_ready, m_tvalid && m_tready && !m_tuser, m_tvalid)

endmodule

bind utf8_cyrillic_lcd_recoder_top ucl_checker u_ucl_checker (.*);

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// UTF-8 Cyrillic LCD recoder testbench
// Streams UTF-8 line text into the recoder under random idling on both
// sides. A clocked driver feeds bytes from a queue, and every accepted byte
// runs through a local recode predictor. A clocked monitor checks each
// character code, its end-of-run flag and its end-of-line flag in order.
// Line width is rewritten between phases, extremes and out-of-range values
// included.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ucl_pkg::*;

	localparam int MAX_COLS     = 40;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0] CYR_CODES [64] = '{
		8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
		8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
		8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
		8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
		8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
		8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
		8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
		8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE
	};

	typedef struct packed {
		logic [7:0] text;
		logic       eol;
	} text_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = '0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	text_item_t text_q[$];
	ucl_res_t   expected_codes[$];

	logic [5:0] width_reg = WIDTH_RESET;
	logic [1:0] held_lead = PEND_NONE;
	logic [5:0] line_pos  = '0;

	bit quiet = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int cycles = 0;
	int err_count = 0;
	int bytes_taken = 0;
	int codes_checked = 0;
	int lines_queued = 0;
	int widths_used = 1;
	int queued_count = 0;

	utf8_cyrillic_lcd_recoder_top #(
		.MAX_COLUMNS(MAX_COLS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),   // [7:0] text_byte
		.s_tlast    (s_tlast),   // line_end
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),   // [7:0] char_code
		.m_tlast    (m_tlast),   // line_done
		.m_tuser    (m_tuser)    // [0] last_of_run
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_width();
		int w;
		w = int'(width_reg);
		if (w == 0) w = 1;
		if (w > MAX_COLS) w = MAX_COLS;
		return w;
	endfunction

	task automatic predict_codes(input logic [7:0] b, input logic eol);
		int         w;
		int         nxt;
		logic       is_end;
		logic       is_lead;
		logic [7:0] lead;
		logic [7:0] code;
		w = eff_width();
		is_lead = (b == LEAD_D0) || (b == LEAD_D1);
		if (int'(line_pos) >= w) begin
			if (eol) begin
				line_pos = '0;
				held_lead = PEND_NONE;
			end
			return;
		end
		nxt = int'(line_pos) + 1;
		is_end = eol || (nxt >= w);
		line_pos = is_end ? 6'd0 : nxt[5:0];
		if (is_end && !eol) line_pos = w[5:0];
		if (held_lead != PEND_NONE) begin
			lead = (held_lead == PEND_D0) ? LEAD_D0 : LEAD_D1;
			held_lead = PEND_NONE;
			if (b >= CONT_LO && b < CONT_HI) begin
				code = CYR_CODES[b[5:0]];
				if (b[5:0] == IDX_YO_UP && lead == LEAD_D0) code = CODE_YO_UP;
				if (b[5:0] == IDX_YO_LO && lead == LEAD_D1) code = CODE_YO_LO;
				expected_codes.push_back(ucl_res_t'{code, 1'b1, is_end});
				return;
			end
			if (is_lead && !is_end) begin
				held_lead = (b == LEAD_D0) ? PEND_D0 : PEND_D1;
				expected_codes.push_back(ucl_res_t'{lead, 1'b1, 1'b0});
				return;
			end
			expected_codes.push_back(ucl_res_t'{lead, 1'b0, 1'b0});
		end else if (is_lead && !is_end) begin
			held_lead = (b == LEAD_D0) ? PEND_D0 : PEND_D1;
			return;
		end
		expected_codes.push_back(ucl_res_t'{b, 1'b1, is_end});
	endtask

	// driver
	always @(posedge clk) begin
		text_item_t item;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_codes(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (text_q.size() != 0) begin
					item = text_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= item.text;
					s_tlast <= item.eol;
					if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ucl_res_t want;
		ucl_res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tuser, m_tlast};
				if (expected_codes.size() == 0) begin
					err_count++;
					$display("%0t: unexpected code %h last %b done %b", $time,
						got.code, got.last, got.done);
				end else begin
					want = expected_codes.pop_front();
					codes_checked++;
					if (got !== want) begin
						err_count++;
						$display("%0t: expected code %h last %b done %b, got %h %b %b",
							$time, want.code, want.last, want.done,
							got.code, got.last, got.done);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eol);
		text_q.push_back('{b, eol});
		queued_count++;
	endtask

	task automatic wait_idle();
		while (text_q.size() != 0 || s_tvalid || expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [5:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		width_reg = value;
		widths_used++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly well-formed Cyrillic text, with stray bytes and broken pairs mixed in
	task automatic queue_line(input int len, input bit close);
		logic [7:0] line[$];
		int         r;
		while (line.size() < len) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				line.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (r < 75) begin
				if ($urandom_range(0, 7) == 0) begin
					line.push_back($urandom_range(0, 1) ? LEAD_D0 : LEAD_D1);
					line.push_back({2'b10, $urandom_range(0, 1) ? IDX_YO_UP : IDX_YO_LO});
				end else begin
					line.push_back($urandom_range(0, 1) ? LEAD_D0 : LEAD_D1);
					line.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
			end else if (r < 85) begin
				line.push_back(8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				line.push_back($urandom_range(0, 1) ? LEAD_D0 : LEAD_D1);
			end else begin
				line.push_back($urandom_range(0, 1) ? LEAD_D0 : LEAD_D1);
				line.push_back(8'($urandom_range(8'hC0, 8'hFF)));
			end
		end
		for (int i = 0; i < len; i++)
			push_byte(line[i], close && (i == len - 1));
		lines_queued++;
	endtask

	task automatic run_phase(input int target);
		int start;
		int len;
		start = queued_count;
		while (queued_count - start < target) begin
			if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 45);
			else len = $urandom_range(1, eff_width() + 4);
			queue_line(len, 1'b1);
		end
		// leave a line open so the next width lands mid-line
		if ($urandom_range(0, 2) == 0) queue_line($urandom_range(1, 4), 1'b0);
	endtask

	initial begin
		logic [5:0] widths[9];
		widths = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd2, 6'd41, 6'd7, 6'd0, 6'd0};
		widths[7] = 6'($urandom_range(0, 63));
		widths[8] = 6'($urandom_range(0, 63));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(LEAD_D0, 1'b0);
		push_byte({2'b10, IDX_YO_UP}, 1'b0);
		push_byte(LEAD_D1, 1'b0);
		push_byte({2'b10, IDX_YO_LO}, 1'b0);
		push_byte(LEAD_D0, 1'b0);
		push_byte(CONT_LO, 1'b0);
		push_byte(LEAD_D1, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(LEAD_D0, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(LEAD_D0, 1'b0);
		push_byte(LEAD_D1, 1'b0);
		push_byte({2'b10, IDX_YO_LO}, 1'b0);
		push_byte(LEAD_D1, 1'b0);
		push_byte(CONT_HI, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(LEAD_D0, 1'b1);
		push_byte(LEAD_D0, 1'b0);
		push_byte(LEAD_D1, 1'b1);
		push_byte(8'h41, 1'b0);
		push_byte(LEAD_D0, 1'b0);
		lines_queued += 3;
		wait_idle();
		// shrink the width to the current position with a lead held
		write_width(6'd2);
		push_byte(8'h42, 1'b0);
		push_byte(8'h43, 1'b1);

		foreach (widths[i]) begin
			wait_idle();
			if (i == 8) quiet = 1'b1;
			write_width(widths[i]);
			run_phase(52);
		end

		wait_idle();
		$display("Covered %0d text bytes in %0d lines over %0d width settings;",
			bytes_taken, lines_queued, widths_used);
		$display("checked %0d character codes, %0d mismatches.", codes_checked, err_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
